### design/xss_pkg.sv
// ----------------------------------------------------------------------------
// xss_pkg
// Shared types and constants for the xoshiro256** generator block.
// ----------------------------------------------------------------------------
package xss_pkg;

	localparam int WORD_W = 64;
	localparam int FRAC_W = 52;
	localparam int PROB_W = 53;
	localparam int CMD_W  = 3;

	// command codes on the request channel
	localparam logic [CMD_W-1:0] CMD_RAW     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_BOUNDED = 3'd1;
	localparam logic [CMD_W-1:0] CMD_BERN    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_JUMP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RESEED  = 3'd4;

	localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94D049BB133111EB;

	localparam logic [WORD_W-1:0] JUMP_POLY [4] = '{
		64'h180ec6d33cfd0aba,
		64'hd5a61266f0c9392c,
		64'ha9582618e03fc9aa,
		64'h39abdc4529b1661c
	};

	typedef enum logic [2:0] {
		OP_RAW,
		OP_BOUNDED,
		OP_BERN,
		OP_JUMP,
		OP_RESEED,
		OP_NONE
	} xss_op_t;

	typedef struct packed {
		xss_op_t             op;
		logic [WORD_W-1:0]   limit;
		logic [WORD_W-1:0]   mask;
		logic [PROB_W-1:0]   probability;
	} xss_item_t;

	typedef enum logic [2:0] {
		BK_RUN,
		BK_JUMP,
		BK_JUMP_END,
		BK_SEED,
		BK_SEED_END
	} xss_bk_state_t;

endpackage

### design/xss_if.sv
// ----------------------------------------------------------------------------
// xss_if
// Channel interfaces: command requests, results and seed writes.
// ----------------------------------------------------------------------------
interface xss_req_if import xss_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [WORD_W-1:0] cap;
	logic [PROB_W-1:0] probability;

	modport source (output valid, cmd, cap, probability, input ready);
	modport sink   (input valid, cmd, cap, probability, output ready);
endinterface

interface xss_rsp_if import xss_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] value;
	logic [FRAC_W-1:0] fraction;
	logic              flag;

	modport source (output valid, value, fraction, flag, input ready);
	modport sink   (input valid, value, fraction, flag, output ready);
endinterface

interface xss_cfg_if import xss_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

### design/xss_front.sv
// ----------------------------------------------------------------------------
// xss_front
// Decodes a request into an operation and precomputes the rejection bound
// and mask of a bounded draw.
// ----------------------------------------------------------------------------
module xss_front import xss_pkg::*; (
	xss_req_if.sink   req,
	output logic      push_valid,
	input  logic      push_ready,
	output xss_item_t push_item
);

	logic [WORD_W-1:0] limit;
	logic [WORD_W-1:0] smear;

	assign limit = req.cap - 64'd1;

	// all-ones mask covering the bound
	always_comb begin
		smear = limit | 64'd1;
		smear = smear | (smear >> 1);
		smear = smear | (smear >> 2);
		smear = smear | (smear >> 4);
		smear = smear | (smear >> 8);
		smear = smear | (smear >> 16);
		smear = smear | (smear >> 32);
	end

	always_comb begin
		push_item.limit       = limit;
		push_item.mask        = smear;
		push_item.probability = req.probability;
		case (req.cmd)
			CMD_RAW:     push_item.op = OP_RAW;
			CMD_BOUNDED: push_item.op = OP_BOUNDED;
			CMD_BERN:    push_item.op = OP_BERN;
			CMD_JUMP:    push_item.op = OP_JUMP;
			CMD_RESEED:  push_item.op = OP_RESEED;
			default:     push_item.op = OP_NONE;
		endcase
	end

	assign push_valid = req.valid;
	assign req.ready  = push_ready;

endmodule

### design/xss_queue.sv
// ----------------------------------------------------------------------------
// xss_queue
// Two-entry queue of decoded requests between front and back.
// ----------------------------------------------------------------------------
module xss_queue import xss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  xss_item_t push_item,
	output logic      head_valid,
	input  logic      pop,
	output xss_item_t head_item
);

	xss_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/xss_back.sv
// ----------------------------------------------------------------------------
// xss_back
// Executes queued requests on the generator words: draws, rejection loop,
// jump sweep and splitmix64 reseed on a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module xss_back import xss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  xss_item_t         head_item,
	output logic              pop,
	input  logic [WORD_W-1:0] seed,
	xss_rsp_if.source         rsp
);

	xss_bk_state_t     state_q;
	xss_bk_state_t     state_nx;

	logic [WORD_W-1:0] words_q [4];
	logic [WORD_W-1:0] accum_q [4];
	logic [WORD_W-1:0] words_nx [4];

	logic [7:0]        jcnt_q;
	logic [3:0]        sub_q;
	logic [1:0]        round_q;
	logic              init_q;
	logic [WORD_W-1:0] x_q;
	logic [WORD_W-1:0] z_q;
	logic [WORD_W-1:0] mac_q;

	logic              rsp_valid_q;
	logic [WORD_W-1:0] value_q;
	logic [FRAC_W-1:0] fraction_q;
	logic              flag_q;

	logic              slot_free;
	logic              adv_en;
	logic              load_rsp;
	logic [WORD_W-1:0] res_value;
	logic [FRAC_W-1:0] res_fraction;
	logic              res_flag;

	logic [WORD_W-1:0] mul5;
	logic [WORD_W-1:0] rot7;
	logic [WORD_W-1:0] raw_out;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] t3;
	logic [WORD_W-1:0] masked;
	logic              accept_draw;
	logic              jbit;
	logic              seed_last;

	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       prod;
	logic [WORD_W-1:0] xg;

	assign slot_free = !rsp_valid_q || rsp.ready;

	// one xoshiro256** step
	assign mul5    = words_q[1] + (words_q[1] << 2);
	assign rot7    = {mul5[56:0], mul5[63:57]};
	assign raw_out = rot7 + (rot7 << 3);
	assign t2      = words_q[2] ^ words_q[0];
	assign t3      = words_q[3] ^ words_q[1];
	assign words_nx[0] = words_q[0] ^ t3;
	assign words_nx[1] = words_q[1] ^ t2;
	assign words_nx[2] = t2 ^ (words_q[1] << 17);
	assign words_nx[3] = {t3[18:0], t3[63:19]};

	assign masked      = raw_out & head_item.mask;
	assign accept_draw = (masked <= head_item.limit);
	assign jbit        = JUMP_POLY[jcnt_q[7:6]][jcnt_q[5:0]];
	assign seed_last   = (sub_q == 4'd8) && (round_q == 2'd3);

	// shared multiplier, low 64 bits built from three partial products
	always_comb begin
		case (sub_q)
			4'd1, 4'd3, 4'd5, 4'd7: mul_a = z_q[31:0];
			default:                mul_a = z_q[63:32];
		endcase
		case (sub_q)
			4'd1, 4'd2: mul_b = MIX_MUL_A[31:0];
			4'd3:       mul_b = MIX_MUL_A[63:32];
			4'd5, 4'd6: mul_b = MIX_MUL_B[31:0];
			default:    mul_b = MIX_MUL_B[63:32];
		endcase
	end

	assign prod = mul_a * mul_b;
	assign xg   = x_q + GOLDEN_INC;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			BK_RUN: begin
				if (head_valid && head_item.op == OP_JUMP) begin
					state_nx = BK_JUMP;
				end else if (head_valid && head_item.op == OP_RESEED) begin
					state_nx = BK_SEED;
				end
			end
			BK_JUMP: begin
				if (jcnt_q == 8'd255) begin
					state_nx = BK_JUMP_END;
				end
			end
			BK_JUMP_END: begin
				if (slot_free) begin
					state_nx = BK_RUN;
				end
			end
			BK_SEED: begin
				if (seed_last) begin
					state_nx = init_q ? BK_RUN : BK_SEED_END;
				end
			end
			BK_SEED_END: begin
				if (slot_free) begin
					state_nx = BK_RUN;
				end
			end
			default: state_nx = BK_RUN;
		endcase
	end

	always_comb begin
		adv_en       = 1'b0;
		pop          = 1'b0;
		load_rsp     = 1'b0;
		res_value    = '0;
		res_fraction = '0;
		res_flag     = 1'b0;
		case (state_q)
			BK_RUN: begin
				if (head_valid) begin
					case (head_item.op)
						OP_RAW, OP_BERN: begin
							res_value    = raw_out;
							res_fraction = raw_out[63:12];
							res_flag     = (head_item.op == OP_BERN) &&
								({1'b0, raw_out[63:12]} < head_item.probability);
							if (slot_free) begin
								adv_en   = 1'b1;
								pop      = 1'b1;
								load_rsp = 1'b1;
							end
						end
						OP_BOUNDED: begin
							res_value    = masked;
							res_fraction = raw_out[63:12];
							// a rejected draw still advances the state
							if (!accept_draw) begin
								adv_en = 1'b1;
							end else if (slot_free) begin
								adv_en   = 1'b1;
								pop      = 1'b1;
								load_rsp = 1'b1;
							end
						end
						OP_JUMP, OP_RESEED: begin
						end
						default: begin
							if (slot_free) begin
								pop      = 1'b1;
								load_rsp = 1'b1;
							end
						end
					endcase
				end
			end
			BK_JUMP: begin
				adv_en = 1'b1;
			end
			BK_JUMP_END, BK_SEED_END: begin
				if (slot_free) begin
					pop      = 1'b1;
					load_rsp = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_SEED;
			init_q      <= 1'b1;
			x_q         <= '0;
			sub_q       <= 4'd0;
			round_q     <= 2'd0;
			jcnt_q      <= 8'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				BK_RUN: begin
					jcnt_q  <= 8'd0;
					sub_q   <= 4'd0;
					round_q <= 2'd0;
					x_q     <= seed;
					init_q  <= 1'b0;
				end
				BK_JUMP: begin
					jcnt_q <= jcnt_q + 8'd1;
				end
				BK_SEED: begin
					if (sub_q == 4'd0) begin
						x_q <= xg;
					end
					if (sub_q == 4'd8) begin
						sub_q   <= 4'd0;
						round_q <= round_q + 2'd1;
					end else begin
						sub_q <= sub_q + 4'd1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			value_q    <= res_value;
			fraction_q <= res_fraction;
			flag_q     <= res_flag;
		end
		if (adv_en) begin
			words_q <= words_nx;
		end
		if (state_q == BK_JUMP) begin
			for (int w = 0; w < 4; w++) begin
				accum_q[w] <= ((jcnt_q == 8'd0) ? '0 : accum_q[w]) ^
					(jbit ? words_q[w] : '0);
			end
		end
		if (state_q == BK_JUMP_END) begin
			words_q <= accum_q;
		end
		if (state_q == BK_SEED) begin
			case (sub_q)
				4'd0:       z_q <= xg ^ (xg >> 30);
				4'd1, 4'd5: mac_q <= prod;
				4'd2, 4'd3, 4'd6, 4'd7: mac_q[63:32] <= mac_q[63:32] + prod[31:0];
				4'd4:       z_q <= mac_q ^ (mac_q >> 27);
				4'd8:       words_q[round_q] <= mac_q ^ (mac_q >> 31);
				default: begin
				end
			endcase
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.value    = value_q;
	assign rsp.fraction = fraction_q;
	assign rsp.flag     = flag_q;

endmodule

### design/xoshiro256ss_generator_top.sv
// ----------------------------------------------------------------------------
// xoshiro256ss_generator_top
// xoshiro256** generator with raw, bounded, bernoulli, jump and reseed
// requests, one result per request.
// ----------------------------------------------------------------------------
// Raw draws, bernoulli trials and unused command codes stream at one request
// per cycle while the result register is free. A bounded draw repeats the
// draw, stepping the generator, for every rejected draw. A jump is decoded,
// then sweeps the 256 bits of the jump polynomial one generator step a cycle
// and then loads the state and returns its result. A reseed is decoded, then
// runs four splitmix64 rounds on one shared 32x32 multiplier and returns its
// result. After reset the same expansion of a zero seed runs before the
// first request executes; requests are queued meanwhile (two entries). A
// result waiting in the result register holds back a raw, bernoulli,
// accepted bounded or unused request; a jump, a reseed or rejected bounded
// draws go ahead meanwhile.
// ----------------------------------------------------------------------------
module xoshiro256ss_generator_top import xss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	xss_req_if.sink   req,
	xss_rsp_if.source rsp,
	xss_cfg_if.sink   cfg
);

	logic [WORD_W-1:0] seed_q;
	logic              push_valid;
	logic              push_ready;
	xss_item_t         push_item;
	logic              head_valid;
	logic              pop;
	xss_item_t         head_item;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg.valid) begin
			seed_q <= cfg.data;
		end
	end

	xss_front u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	xss_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.head_valid (head_valid),
		.pop        (pop),
		.head_item  (head_item)
	);

	xss_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.seed       (seed_q),
		.rsp        (rsp)
	);

endmodule
